// File: rtl/dqp_pkg.sv
// Shared types, constants and character classes for the dotted-quad parser.
package dqp_pkg;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    localparam logic [8:0]  ACC_SAT   = 9'd256;
    localparam logic [1:0]  LAST_OCT  = 2'd3;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_DIGIT = 2'd1,
        PH_TRAIL = 2'd2,
        PH_FAULT = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  idx;
        logic [8:0]  accum;
        logic        seen;
        logic [31:0] octets;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic        ok;
        logic [31:0] addr;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:  PH_LEAD,
        idx:    2'd0,
        accum:  9'd0,
        seen:   1'b0,
        octets: 32'd0
    };

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: rtl/dqp_step.sv
// Combinational next-state logic for one character of the parser.
module dqp_step (
    input  logic [7:0]            ch,
    input  dqp_pkg::parse_state_t cur,
    output dqp_pkg::parse_state_t nxt,
    output dqp_pkg::parse_result_t res
);
    import dqp_pkg::*;

    phase_t      ph;
    logic        done;
    logic        clr;
    logic [11:0] prod;

    // accum <= 256, so accum*10 + 9 fits in 12 bits
    assign prod = {cur.accum, 3'b000} + {2'b00, cur.accum, 1'b0} + {8'd0, ch[3:0]};

    always_comb begin
        nxt  = cur;
        res  = '0;
        ph   = cur.phase;
        done = 1'b0;
        clr  = 1'b0;

        if (ph == PH_LEAD) begin
            if ((ch != CH_NUL) && is_blank(ch)) begin
                done = 1'b1;
            end else begin
                ph = PH_DIGIT;
            end
        end

        if (!done && (ph == PH_DIGIT)) begin
            if (is_digit(ch)) begin
                nxt.accum = (prod > {3'b000, ACC_SAT}) ? ACC_SAT : prod[8:0];
                nxt.seen  = 1'b1;
                done      = 1'b1;
            end else if (!cur.seen || cur.accum[8] ||
                         ((cur.idx != LAST_OCT) && (ch != CH_DOT))) begin
                ph = PH_FAULT;
            end else begin
                // octet 0 lands in bits 31:24
                nxt.octets[{~cur.idx, 3'b000} +: 8] = cur.accum[7:0];
                nxt.accum = 9'd0;
                nxt.seen  = 1'b0;
                if (cur.idx != LAST_OCT) begin
                    nxt.idx = cur.idx + 2'd1;
                    done    = 1'b1;
                end else begin
                    ph = PH_TRAIL;
                end
            end
        end

        if (!done && (ph == PH_TRAIL)) begin
            if (ch == CH_NUL) begin
                res.emit = 1'b1;
                res.ok   = 1'b1;
                res.addr = nxt.octets;
                clr      = 1'b1;
                done     = 1'b1;
            end else if (is_blank(ch)) begin
                done = 1'b1;
            end else begin
                ph = PH_FAULT;
            end
        end

        if (!done && (ph == PH_FAULT)) begin
            if (ch == CH_NUL) begin
                res.emit = 1'b1;
                res.ok   = 1'b0;
                res.addr = nxt.octets;
                clr      = 1'b1;
            end
        end

        if (clr) begin
            nxt = STATE_RESET;
        end else begin
            nxt.phase = ph;
        end
    end

endmodule

// File: rtl/dqp_out_reg.sv
// Result register on the master side; frees itself in the cycle it is taken.
module dqp_out_reg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        ok,
    input  logic [31:0] addr,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tuser
);
    logic        valid_reg, valid_next;
    logic [31:0] addr_reg;
    logic        ok_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg <= addr;
            ok_reg   <= ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = addr_reg;
    assign m_tuser  = ok_reg;

endmodule

// File: rtl/dotted_quad_ipv4_parser.sv
// Top level of the streaming dotted-quad IPv4 address parser.
//
//  channel | dir | payload                         | transfer meaning
//  --------+-----+---------------------------------+------------------------------
//  s_      | in  | tdata[7:0] = ch                 | one string character, 0 ends it
//  m_      | out | tdata[31:0] = address,          | one result per terminated string
//          |     | tuser[0] = valid_res            |
//
// One character per cycle, sustained unless m_tready stalls. A character sits
// in the input register, where the parse state and result register are updated.
// m_tvalid rises once the result register has loaded the terminator's result.
// aresetn (synchronous) empties both registers and returns the parser to the
// leading-whitespace phase. A stall on m_tready backs up through the result
// register to s_tready; while a result is held, every character waits.
module dotted_quad_ipv4_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic        m_tuser    // [0] valid_res
);
    import dqp_pkg::*;

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    ch_reg;
    parse_state_t  state_reg, state_next;
    parse_result_t res;
    logic          out_space;
    logic          advance;
    logic          out_load;

    // A character may be processed unless it would emit into a full result reg;
    // simpler to gate every advance on output space; one per cycle while it has room.
    assign advance  = in_valid_reg && out_space;
    assign s_tready = !in_valid_reg || out_space;
    assign out_load = advance && res.emit;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    dqp_step u_step (
        .ch  (ch_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (res)
    );

    dqp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .ok       (res.ok),
        .addr     (res.addr),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a string result always leaves the parser in its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after result");

    // the digit accumulator saturates at 256
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.accum <= ACC_SAT)
        else $error("accumulator above saturation value");

    // a good result only comes after all four octets
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res.ok) |->
            ((state_reg.phase == PH_TRAIL) ||
             ((state_reg.phase == PH_DIGIT) && (state_reg.idx == LAST_OCT))))
        else $error("valid result before the fourth octet");

    // an empty input register never stalls the slave side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

// File: tb/sv/dotted_quad_ipv4_parser_test.sv
// Self-checking stream testbench for the dotted-quad IPv4 address parser.
`timescale 1ns / 1ps

module dotted_quad_ipv4_parser_test;
    import dqp_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;  // several times the slowest clean run
    localparam int          HOLD_CYCLES   = 300;     // long output hold-off
    localparam int          TAIL_CYCLES   = 8;       // settle time before the final result check
    localparam int unsigned OCTET_MAX     = 255;
    localparam int          MAX_PRINTS    = 20;
    localparam int          RANDOM_STRS   = 24;      // per idle mix, ~16 chars each

    // One expected result: the valid flag and the packed octets.
    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } addr_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] address
    logic        m_tuser;           // [0] valid_res

    dotted_quad_ipv4_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Characters waiting to be sent, and results the parser still owes us.
    logic [7:0]   char_queue[$];
    addr_result_t addr_due[$];

    // Shadow parser state, advanced once per accepted character.
    phase_t      sh_phase  = PH_LEAD;
    logic [1:0]  sh_idx    = 2'd0;
    logic [8:0]  sh_accum  = 9'd0;
    logic        sh_seen   = 1'b0;
    logic [31:0] sh_octets = 32'd0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_cnt = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int good_seen = 0;
    int cycle_cnt = 0;

    // Long-hold request: the stimulus toggles hold_trig, the counter below
    // then keeps m_tready low until hold_left has counted down from HOLD_CYCLES.
    logic hold_trig = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    bit   tx_busy;

    function automatic bit blank_ch(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] any_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic clear_shadow();
        sh_phase  = PH_LEAD;
        sh_idx    = 2'd0;
        sh_accum  = 9'd0;
        sh_seen   = 1'b0;
        sh_octets = 32'd0;
    endtask

    // Advance the shadow parser by one character; a terminator queues a result.
    task automatic parse_char(input logic [7:0] c);
        int unsigned  v;
        bit           done;
        bit           is_dig;
        addr_result_t r;
        done   = 1'b0;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

        if (sh_phase == PH_LEAD) begin
            if (c != CH_NUL && blank_ch(c))
                done = 1'b1;
            else
                sh_phase = PH_DIGIT;
        end

        if (!done && sh_phase == PH_DIGIT) begin
            if (is_dig) begin
                // accumulator saturates instead of wrapping
                v = int'(sh_accum) * 10 + int'(c) - int'(CH_ZERO);
                sh_accum = (v > int'(ACC_SAT)) ? ACC_SAT : v[8:0];
                sh_seen  = 1'b1;
                done     = 1'b1;
            end else if (!sh_seen || sh_accum > OCTET_MAX ||
                         (sh_idx < LAST_OCT && c != CH_DOT)) begin
                sh_phase = PH_FAULT;
            end else begin
                sh_octets = sh_octets | (32'(sh_accum[7:0]) << (24 - 8 * int'(sh_idx)));
                sh_accum  = 9'd0;
                sh_seen   = 1'b0;
                if (sh_idx < LAST_OCT) begin
                    sh_idx = sh_idx + 2'd1;
                    done   = 1'b1;
                end else begin
                    // fourth octet taken; its closing char falls through as trailer
                    sh_phase = PH_TRAIL;
                end
            end
        end

        if (!done && sh_phase == PH_TRAIL) begin
            if (c == CH_NUL) begin
                r.ok   = 1'b1;
                r.addr = sh_octets;
                addr_due.push_back(r);
                clear_shadow();
                done = 1'b1;
            end else if (blank_ch(c)) begin
                done = 1'b1;
            end else begin
                sh_phase = PH_FAULT;
            end
        end

        // fault: swallow everything up to the terminator
        if (!done && c == CH_NUL) begin
            r.ok   = 1'b0;
            r.addr = sh_octets;
            addr_due.push_back(r);
            clear_shadow();
        end
    endtask

    // Sender: one character per transfer, random gaps between transfers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            tx_busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata);
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= char_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the output side.
    always @(posedge aclk) begin
        hold_seen <= hold_trig;
        if (hold_trig != hold_seen)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        addr_result_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (addr_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result ok=%0b addr=%08h",
                                            m_tuser, m_tdata));
                end else begin
                    e = addr_due.pop_front();
                    if (m_tuser !== e.ok)
                        flag_mismatch($sformatf("valid_res got %0b want %0b (addr want %08h)",
                                                m_tuser, e.ok, e.addr));
                    if (m_tdata !== e.addr)
                        flag_mismatch($sformatf("address got %08h want %08h",
                                                m_tdata, e.addr));
                    if (e.ok)
                        good_seen++;
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, addr_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            char_queue.push_back(txt[i]);
        char_queue.push_back(CH_NUL);
        strings_sent++;
    endtask

    // Mostly dotted quads with random content and the odd defect; the rest noise.
    task automatic queue_random_string();
        int    r;
        int    n_oct;
        int    v;
        string txt;
        r = $urandom_range(0, 99);
        txt = "";
        if (r < 75) begin
            repeat ($urandom_range(0, 2)) txt = {txt, string'(any_blank())};
            n_oct = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
            for (int k = 0; k < n_oct; k++) begin
                if (k > 0)
                    txt = {txt, string'(($urandom_range(0, 19) == 0) ?
                                        8'($urandom_range(1, 255)) : CH_DOT)};
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    // empty octet
                end else if (r < 9) begin
                    repeat ($urandom_range(4, 20)) txt = {txt, string'(any_digit())};
                end else begin
                    v = (r < 14) ? $urandom_range(256, 999) : $urandom_range(0, 255);
                    if ($urandom_range(0, 9) == 0)
                        repeat ($urandom_range(1, 3)) txt = {txt, "0"};
                    txt = {txt, $sformatf("%0d", v)};
                end
            end
            repeat ($urandom_range(0, 2)) txt = {txt, string'(any_blank())};
            if ($urandom_range(0, 9) == 0)
                txt = {txt, string'(8'($urandom_range(1, 255)))};
        end else begin
            repeat ($urandom_range(0, 12)) begin
                case ($urandom_range(0, 3))
                    0: txt = {txt, string'(any_digit())};
                    1: txt = {txt, "."};
                    2: txt = {txt, string'(any_blank())};
                    default: txt = {txt, string'(8'($urandom_range(1, 255)))};
                endcase
            end
        end
        queue_text(txt);
    endtask

    // Wait until every queued character is sent and every result is back.
    task automatic drain();
        while (char_queue.size() != 0 || s_tvalid || addr_due.size() != 0)
            @(posedge aclk);
    endtask

    // Directed strings: extremes, whitespace, each fault path.
    string directed_strs[] = '{
        "0.0.0.0",
        "255.255.255.255",
        "\040\011\012\013\014\0151.2.3.4\040\011\015\012",
        "",
        "\040\011",
        "256.1.1.1",
        "1.2.3.999",
        "1..2.3",
        ".1.2.3",
        "1.2.3",
        "1.2.3.",
        "1.2.3.4x",
        "1.2.3.4 5",
        "1.2.3.4.5",
        "12345678901234567890.1.1.1",
        "007.08.9.010",
        "1 .2.3.4",
        "\200",
        "1.2.3.\377",
        "10.20.30.40\011"
    };

    initial begin
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{75, 0}, '{0, 75}, '{36, 36}};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, full throughput
        foreach (directed_strs[i])
            queue_text(directed_strs[i]);
        drain();

        // hold the output while the sender keeps streaming short strings,
        // so the result register fills and s_tready drops
        hold_trig <= ~hold_trig;
        repeat (2) @(posedge aclk);
        repeat (40) queue_text("1.2.3.4");
        drain();

        // random part under each idle/stall mix
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_mix[p][0];
            recv_stall_pct = idle_mix[p][1];
            repeat (RANDOM_STRS) queue_random_string();
            drain();
        end

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (addr_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", addr_due.size()));

        $display("Parsed %0d strings: %0d well-formed, %0d rejected, %0d mismatches.",
                 strings_sent, good_seen, results_seen - good_seen, err_cnt);
        $display("Covered whitespace, octet extremes, every fault path, %s %0d-cycle hold.",
                 "four idle mixes and a", HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
